// File: hw/rtl/cfpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpq_pkg: shared constants, types and helpers
// Sizes, codes and the credit reload function of the credit-fair priority
// queue.
// ----------------------------------------------------------------------------
package cfpq_pkg;

    localparam int LEVELS      = 3;
    localparam int QUEUE_DEPTH = 128;
    localparam int DATA_W      = 32;

    // Widths of the request and response fields.
    localparam int LEVEL_W  = 3;
    localparam int SERVED_W = 2;
    localparam int SHARE_W  = 5;
    localparam int CREDIT_W = 6;

    localparam int Q_W       = $clog2(LEVELS);
    localparam int IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int PROD_W    = Q_W + 1 + SHARE_W;

    localparam logic [SHARE_W-1:0]  SHARE_RESET = SHARE_W'(2);
    localparam logic [CREDIT_W-1:0] CREDIT_MAX  = '1;
    localparam logic [Q_W-1:0]      TOP_Q       = Q_W'(LEVELS - 1);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [DATA_W-1:0]   t_data;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [SERVED_W-1:0] t_served;
    typedef logic [SHARE_W-1:0]  t_share;
    typedef logic [CREDIT_W-1:0] t_credit;
    typedef logic [Q_W-1:0]      t_qsel;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [FILL_W-1:0]   t_fill;
    typedef logic [ADDR_W-1:0]   t_addr;

    // Credit a level gets back when the scan passes over it, saturated to
    // the counter range.
    function automatic t_credit reload_credit(input t_qsel q, input t_share share);
        logic [PROD_W-1:0] prod;
        prod = (PROD_W'(LEVELS) - PROD_W'(q)) * PROD_W'(share);
        if (prod > PROD_W'(CREDIT_MAX)) begin
            return CREDIT_MAX;
        end
        return CREDIT_W'(prod);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cfpq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpq_if: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfpq_req_if;
    logic             valid;
    logic             ready;
    logic             op;
    cfpq_pkg::t_level level;
    cfpq_pkg::t_data  item_in;

    modport source (output valid, output op, output level, output item_in, input ready);
    modport sink   (input valid, input op, input level, input item_in, output ready);
endinterface

interface cfpq_rsp_if;
    logic              valid;
    logic              ready;
    cfpq_pkg::t_data   item_out;
    logic              got_item;
    cfpq_pkg::t_served served_level;
    logic              dropped;

    modport source (output valid, output item_out, output got_item, output served_level,
                    output dropped, input ready);
    modport sink   (input valid, input item_out, input got_item, input served_level,
                    input dropped, output ready);
endinterface

interface cfpq_cfg_if;
    logic             valid;
    logic             ready;
    cfpq_pkg::t_share share_per_level;

    modport source (output valid, output share_per_level, input ready);
    modport sink   (input valid, input share_per_level, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cfpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpq_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/credit_fair_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// credit_fair_priority_queue: strict priority queue with credit fairness
// Per-level FIFOs in one shared RAM; pops scan levels top down and are
// limited by per-level credits that reload when a level is passed over.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                   Transfer
//  i_req    in   op, level, item_in                        valid && ready
//  o_rsp    out  item_out, got_item, served_level, dropped valid && ready
//  i_cfg    in   share_per_level                           valid && ready
//
//  One request is taken every cycle while o_rsp does not stall; its response
//  passes the queue RAM's registered read and then the output register.
//  Reset is synchronous and active low. It clears the queue pointers and
//  reloads the credits; the RAM needs no clearing pass since only written
//  entries are ever read.
//  i_req.ready drops only while both the read stage and the output register
//  are held by a stalled o_rsp. i_cfg is always ready.
// ----------------------------------------------------------------------------
module credit_fair_priority_queue (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cfpq_req_if.sink   i_req,
    cfpq_cfg_if.sink   i_cfg,
    cfpq_rsp_if.source o_rsp
);
    import cfpq_pkg::*;

    // Queue pointers, fill counts and credits, one of each per level.
    t_idx    r_head   [LEVELS];
    t_idx    r_tail   [LEVELS];
    t_fill   r_fill   [LEVELS];
    t_credit r_credit [LEVELS];
    t_idx    n_head   [LEVELS];
    t_idx    n_tail   [LEVELS];
    t_fill   n_fill   [LEVELS];
    t_credit n_credit [LEVELS];
    t_share  r_share;

    // Read stage: response fields waiting for the RAM data.
    logic    r_s1_valid;
    logic    r_s1_got;
    t_served r_s1_served;
    logic    r_s1_drop;

    // Output register.
    logic    r_out_valid;
    t_data   r_out_item;
    logic    r_out_got;
    t_served r_out_served;
    logic    r_out_drop;

    logic    accept;
    logic    s1_move;
    logic    push_top;
    t_qsel   push_q;
    t_qsel   sel_q;
    t_qsel   ram_q;
    t_idx    ram_idx;
    t_idx    front_idx;
    logic    found;
    logic    pop_hit;
    logic    wr_en;
    logic    rd_en;
    logic    got;
    logic    drop;
    t_addr   ram_addr;
    t_data   ram_rdata;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // A level beyond the last one goes to the front of the top queue.
    assign push_top = {1'b0, i_req.level} >= (LEVEL_W + 1)'(LEVELS);
    assign push_q   = push_top ? TOP_Q : Q_W'(i_req.level);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_credit  = r_credit;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        got       = 1'b0;
        drop      = 1'b0;
        found     = 1'b0;
        pop_hit   = 1'b0;
        sel_q     = TOP_Q;
        ram_q     = push_q;
        ram_idx   = r_tail[push_q];
        front_idx = (r_head[push_q] == '0) ? IDX_W'(QUEUE_DEPTH - 1)
                                           : r_head[push_q] - 1'b1;

        if (accept) begin
            if (i_req.op == OP_PUSH) begin
                if (r_fill[push_q] == FILL_W'(QUEUE_DEPTH)) begin
                    drop = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    if (push_top) begin
                        ram_idx         = front_idx;
                        n_head[push_q]  = front_idx;
                    end else begin
                        n_tail[push_q] = (r_tail[push_q] == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                         : r_tail[push_q] + 1'b1;
                    end
                    n_fill[push_q] = r_fill[push_q] + 1'b1;
                end
            end else begin
                // Scan from the top; every level passed over gets its reload.
                for (int k = LEVELS - 1; k >= 0; k--) begin
                    if (!found) begin
                        if (r_fill[k] != '0 && r_credit[k] != '0) begin
                            found       = 1'b1;
                            sel_q       = Q_W'(k);
                            n_credit[k] = r_credit[k] - 1'b1;
                        end else begin
                            n_credit[k] = reload_credit(Q_W'(k), r_share);
                        end
                    end
                end
                // With every level passed over, the top queue still serves.
                pop_hit = found || (r_fill[TOP_Q] != '0);
                if (pop_hit) begin
                    rd_en         = 1'b1;
                    got           = 1'b1;
                    ram_q         = sel_q;
                    ram_idx       = r_head[sel_q];
                    n_head[sel_q] = (r_head[sel_q] == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                    : r_head[sel_q] + 1'b1;
                    n_fill[sel_q] = r_fill[sel_q] - 1'b1;
                end
            end
        end
    end

    assign ram_addr = ADDR_W'(ram_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ram_idx);

    cfpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data (i_req.item_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_head[k]   <= '0;
                r_tail[k]   <= '0;
                r_fill[k]   <= '0;
                r_credit[k] <= reload_credit(Q_W'(k), SHARE_RESET);
            end
            r_share <= SHARE_RESET;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_credit <= n_credit;
            if (i_cfg.valid) begin
                r_share <= i_cfg.share_per_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_got    <= got;
            r_s1_served <= got ? SERVED_W'(sel_q) : '0;
            r_s1_drop   <= drop;
        end
        if (s1_move) begin
            r_out_item   <= r_s1_got ? ram_rdata : '0;
            r_out_got    <= r_s1_got;
            r_out_served <= r_s1_served;
            r_out_drop   <= r_s1_drop;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.item_out     = r_out_item;
    assign o_rsp.got_item     = r_out_got;
    assign o_rsp.served_level = r_out_served;
    assign o_rsp.dropped      = r_out_drop;

endmodule
`default_nettype wire

// File: hw/rtl/cfpq_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfpq_chk: port-level checks for the credit-fair priority queue
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cfpq_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire cfpq_pkg::t_data   i_item_out,
    input wire logic              i_got_item,
    input wire cfpq_pkg::t_served i_served_level,
    input wire logic              i_dropped
);
    import cfpq_pkg::*;

    // A response with no item carries zero data and level zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_got_item) |-> (i_item_out == '0 && i_served_level == '0))
        else $error("response without an item carries nonzero fields");

    // A request cannot both return an item and be dropped.
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_dropped) |-> !i_got_item)
        else $error("dropped push reports a returned item");

    // The block stalls requests only behind a held response.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> (i_rsp_valid && !i_rsp_ready))
        else $error("request stalled without a held response");

    // No response is presented right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // A held response keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_item_out) && $stable(i_got_item)
             && $stable(i_served_level) && $stable(i_dropped)))
        else $error("held response changed");

endmodule

bind credit_fair_priority_queue cfpq_chk u_cfpq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_item_out     (o_rsp.item_out),
    .i_got_item     (o_rsp.got_item),
    .i_served_level (o_rsp.served_level),
    .i_dropped      (o_rsp.dropped)
);
`default_nettype wire
